>>> sv/sdspi_pkg.sv
// Types, codes and helpers shared by the SD card SPI host sequencer.
`timescale 1ns / 1ps
package sdspi_pkg;

    // Request and event codes carried in action
    localparam logic [2:0] ACT_INIT  = 3'd0;
    localparam logic [2:0] ACT_READ  = 3'd1;
    localparam logic [2:0] ACT_WRITE = 3'd2;
    localparam logic [2:0] ACT_BYTE  = 3'd3;
    localparam logic [2:0] ACT_TICK  = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_READY_TO   = 3'd0;
    localparam logic [2:0] CFG_WBUSY_TO   = 3'd1;
    localparam logic [2:0] CFG_OPCOND_TO  = 3'd2;
    localparam logic [2:0] CFG_RETRY_GAP  = 3'd3;
    localparam logic [2:0] CFG_RESP_TRIES = 3'd4;
    localparam int unsigned CFG_DATA_W    = 13;

    // Completion status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_RESET     = 4'd1;
    localparam logic [3:0] ST_VOLTAGE   = 4'd2;
    localparam logic [3:0] ST_OPCOND    = 4'd3;
    localparam logic [3:0] ST_NO_CARD   = 4'd4;
    localparam logic [3:0] ST_REJECTED  = 4'd5;
    localparam logic [3:0] ST_TOKEN_TO  = 4'd6;
    localparam logic [3:0] ST_BAD_TOKEN = 4'd7;
    localparam logic [3:0] ST_WR_REJECT = 4'd8;
    localparam logic [3:0] ST_BUSY_TO   = 4'd9;

    // Card types
    localparam logic [1:0] CARD_NONE = 2'd0;
    localparam logic [1:0] CARD_SD1  = 2'd1;
    localparam logic [1:0] CARD_SD2  = 2'd2;
    localparam logic [1:0] CARD_HC   = 2'd3;

    // Command numbers
    localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
    localparam logic [5:0] CMD_IF_COND  = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD = 6'd9;
    localparam logic [5:0] CMD_RD_BLOCK = 6'd17;
    localparam logic [5:0] CMD_WR_BLOCK = 6'd24;
    localparam logic [5:0] CMD_OP_COND  = 6'd41;
    localparam logic [5:0] CMD_APP      = 6'd55;
    localparam logic [5:0] CMD_READ_OCR = 6'd58;

    // Protocol bytes and limits
    localparam logic [7:0]  BYTE_IDLE    = 8'hFF;
    localparam logic [7:0]  TOKEN_START  = 8'hFE;
    localparam logic [7:0]  DRESP_MASK   = 8'h1F;
    localparam logic [7:0]  DRESP_OK     = 8'h05;
    localparam logic [31:0] IF_COND_ARG  = 32'h0000_01AA;
    localparam logic [31:0] HCS_ARG      = 32'h4000_0000;
    localparam logic [9:0]  BLOCK_BYTES  = 10'd512;
    localparam logic [9:0]  CSD_BYTES    = 10'd16;
    localparam logic [12:0] MS_MAX       = 13'd8191;
    localparam logic [13:0] OP_MAX       = 14'd16383;

    typedef enum logic [3:0] {
        PH_IDLE, PH_IDLECLK, PH_WAITRDY, PH_FRAME, PH_R1, PH_RESP4, PH_RELEASE,
        PH_GAP, PH_TOKEN, PH_RDATA, PH_PREWAIT, PH_WTOKEN, PH_WDATA, PH_WTAIL, PH_BUSY
    } phase_t;

    typedef enum logic [2:0] {
        GO_FINISH, GO_CMD8, GO_ACMD_FIRST, GO_OPCHECK, GO_CSD, GO_CSDDONE, GO_INITOK
    } go_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] block_address;
        logic [7:0]  rx_byte;
        logic [7:0]  write_byte;
    } in_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        chip_select_n;
        logic        fast_clock;
        logic        read_valid;
        logic [7:0]  read_byte;
        logic        need_write_byte;
        logic        done_res;
        logic [3:0]  status;
        logic [1:0]  card_type;
        logic [31:0] sector_count;
        logic        busy_res;
    } out_t;

    // Build a six-byte command frame with its fixed CRC
    function automatic logic [47:0] make_frame(input logic [5:0] cmd, input logic [31:0] arg);
        logic [7:0] crc;
        crc = (cmd == CMD_GO_IDLE) ? 8'h95 : (cmd == CMD_IF_COND) ? 8'h87 : 8'h01;
        return {2'b01, cmd, arg, crc};
    endfunction

endpackage

>>> sv/sd_card_spi_host_sequencer_unit.sv
// SD card SPI-mode host sequencer: one registered step per input beat.
//
// Usage: each input beat on in_valid/in_ready is a host request (init, read,
// write), a finished SPI byte exchange carrying the received byte, or a 1 ms
// tick. Each accepted beat yields exactly one output beat on out_valid/
// out_ready, giving the next byte to exchange, chip select, clock speed,
// read data, write-data request and completion status.
// The output beat appears in the cycle after its input beat is taken; a new
// beat is taken every cycle while the output register can drain, so throughput
// is one beat per cycle. The step logic lies between the state registers and the output register.
// The output register holds one result; while it is full and out_ready is
// low, in_ready drops, and it rises again in the cycle the result is taken.
// Reset (rst_n low) empties the output register, returns the sequencer to
// idle with no card detected, chip select high and slow clock, and loads
// the configuration registers with their default timeouts.
// Configuration writes on cfg_write/cfg_index/cfg_data take effect at once
// and should only be made while no request is in progress.
`timescale 1ns / 1ps
module sd_card_spi_host_sequencer_unit #(
    parameter int unsigned IDLE_CLOCK_BYTES = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  sdspi_pkg::in_t                      in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output sdspi_pkg::out_t                     out_data,
    input  logic                                cfg_write,
    input  logic [2:0]                          cfg_index,
    input  logic [sdspi_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sdspi_pkg::*;

    localparam logic [9:0] IDLE_LIMIT = 10'(IDLE_CLOCK_BYTES + 1);

    // Configuration
    logic [11:0] ready_to_reg, wbusy_to_reg;
    logic [12:0] opcond_to_reg;
    logic [7:0]  gap_reg;
    logic [3:0]  tries_reg;

    // Sequencer state
    phase_t      phase_reg, phase_next;
    go_t         go_reg, go_next;
    logic [9:0]  bc_reg, bc_next;
    logic [12:0] ms_reg, ms_next;
    logic [13:0] op_reg, op_next;
    logic [3:0]  tc_reg, tc_next;
    logic [47:0] frame_reg, frame_next;
    logic        v2_reg, v2_next;
    logic [1:0]  dtype_reg, dtype_next;
    logic [31:0] sectors_reg, sectors_next;
    logic        cs_n_reg, cs_n_next;
    logic        fast_reg, fast_next;
    logic [3:0]  hold_reg, hold_next;
    logic        r1_zero_reg, r1_zero_next;
    logic [7:0]  regb_reg [16];

    // Output register
    logic        out_valid_reg;
    out_t        out_reg, out_next;

    // Step-local signals
    logic        accept;
    logic        rb_we;
    logic [3:0]  rb_idx;
    logic        do_cmd;
    logic [5:0]  cmd_sel;
    logic [31:0] arg_sel;
    logic        done;
    logic [3:0]  stat;
    logic        rv;
    logic [7:0]  r1;
    logic        r1_hit;
    logic [5:0]  cmd_cur;
    logic        is_csd;
    logic [9:0]  bc_inc;
    logic [3:0]  tc_inc;
    logic [12:0] ms_inc;
    logic [31:0] csd_sectors;
    logic [44:0] cap;
    logic [4:0]  shamt;
    logic [12:0] cs_v0;
    logic [21:0] cs_v1;
    logic [31:0] cs_v1_plus;

    assign accept    = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cmd_cur   = frame_reg[45:40];
    assign is_csd    = (cmd_cur == CMD_SEND_CSD);
    assign bc_inc    = bc_reg + 10'd1;
    assign tc_inc    = tc_reg + 4'd1;
    assign ms_inc    = (ms_reg < MS_MAX) ? ms_reg + 13'd1 : ms_reg;

    // Work out capacity from the stored CSD
    always_comb
    begin
        cs_v0      = {regb_reg[6][1:0], regb_reg[7], regb_reg[8][7:6]};
        shamt      = 5'({regb_reg[9][1:0], regb_reg[10][7]}) + 5'd2 + 5'(regb_reg[5][3:0]);
        cap        = 45'(cs_v0 + 13'd1) << shamt;
        cs_v1      = {regb_reg[7][5:0], regb_reg[8], regb_reg[9]};
        cs_v1_plus = 32'(cs_v1) + 32'd1;
        case (regb_reg[0][7:6])
            2'd0:    csd_sectors = cap[40:9];
            2'd1:    csd_sectors = {cs_v1_plus[21:0], 10'd0};
            default: csd_sectors = sectors_reg;
        endcase
    end

    // Next state for one step
    always_comb
    begin
        phase_next   = phase_reg;
        go_next      = go_reg;
        bc_next      = bc_reg;
        ms_next      = ms_reg;
        op_next      = op_reg;
        tc_next      = tc_reg;
        frame_next   = frame_reg;
        v2_next      = v2_reg;
        dtype_next   = dtype_reg;
        sectors_next = sectors_reg;
        cs_n_next    = cs_n_reg;
        fast_next    = fast_reg;
        hold_next    = hold_reg;
        r1_zero_next = r1_zero_reg;
        rb_we        = 1'b0;
        rb_idx       = 4'd0;
        do_cmd       = 1'b0;
        cmd_sel      = CMD_GO_IDLE;
        arg_sel      = 32'd0;
        done         = 1'b0;
        stat         = ST_OK;
        rv           = 1'b0;
        r1           = BYTE_IDLE;
        r1_hit       = 1'b0;

        if (in_data.action <= ACT_WRITE && phase_reg == PH_IDLE) begin
            // Start a request
            if (in_data.action == ACT_INIT) begin
                dtype_next   = CARD_NONE;
                sectors_next = 32'd0;
                v2_next      = 1'b0;
                fast_next    = 1'b0;
                cs_n_next    = 1'b1;
                phase_next   = PH_IDLECLK;
                bc_next      = 10'd0;
            end else if (dtype_reg == CARD_NONE) begin
                done = 1'b1;
                stat = ST_NO_CARD;
            end else begin
                do_cmd  = 1'b1;
                cmd_sel = (in_data.action == ACT_READ) ? CMD_RD_BLOCK : CMD_WR_BLOCK;
                arg_sel = (dtype_reg == CARD_HC) ? in_data.block_address
                                                 : {in_data.block_address[22:0], 9'd0};
            end
        end else if (in_data.action == ACT_BYTE) begin
            // Advance on a completed exchange
            case (phase_reg)
                PH_IDLECLK:
                begin
                    bc_next = bc_inc;
                    if (bc_inc >= IDLE_LIMIT) begin
                        do_cmd  = 1'b1;
                        cmd_sel = CMD_GO_IDLE;
                    end
                end
                PH_PREWAIT:
                begin
                    if (in_data.rx_byte == BYTE_IDLE) begin
                        phase_next = PH_WAITRDY;
                        ms_next    = 13'd0;
                    end else if (ms_reg > 13'(ready_to_reg)) begin
                        phase_next = PH_RELEASE; cs_n_next = 1'b1;
                        go_next = GO_FINISH; hold_next = ST_BUSY_TO;
                    end
                end
                PH_WAITRDY:
                begin
                    if (in_data.rx_byte == BYTE_IDLE || ms_reg > 13'(ready_to_reg)) begin
                        phase_next = PH_FRAME;
                        bc_next    = 10'd0;
                    end
                end
                PH_FRAME:
                begin
                    bc_next = bc_inc;
                    if (bc_inc >= 10'd6) begin
                        phase_next = PH_R1;
                        tc_next    = 4'd0;
                    end
                end
                PH_R1:
                begin
                    if (!in_data.rx_byte[7]) begin
                        r1     = in_data.rx_byte;
                        r1_hit = 1'b1;
                    end else begin
                        tc_next = tc_inc;
                        if (tc_inc == 4'd0 || tc_inc >= tries_reg) begin
                            r1_hit = 1'b1;
                        end
                    end
                end
                PH_RESP4:
                begin
                    rb_we   = 1'b1;
                    rb_idx  = {2'b00, bc_reg[1:0]};
                    bc_next = bc_inc;
                    if (bc_inc >= 10'd4) begin
                        phase_next = PH_RELEASE;
                        cs_n_next  = 1'b1;
                        hold_next  = ST_OK;
                        if (cmd_cur == CMD_IF_COND) begin
                            if (regb_reg[2][3:0] == 4'd1 && in_data.rx_byte == 8'hAA) begin
                                v2_next = 1'b1;
                                go_next = GO_ACMD_FIRST;
                            end else begin
                                go_next   = GO_FINISH;
                                hold_next = ST_VOLTAGE;
                            end
                        end else begin
                            dtype_next = regb_reg[0][6] ? CARD_HC : CARD_SD2;
                            go_next    = GO_CSD;
                        end
                    end
                end
                PH_RELEASE:
                begin
                    case (go_reg)
                        GO_CMD8:
                        begin
                            do_cmd = 1'b1; cmd_sel = CMD_IF_COND; arg_sel = IF_COND_ARG;
                        end
                        GO_ACMD_FIRST:
                        begin
                            op_next = 14'd0; do_cmd = 1'b1; cmd_sel = CMD_APP;
                        end
                        GO_OPCHECK:
                        begin
                            if (r1_zero_reg) begin
                                do_cmd = 1'b1;
                                if (v2_reg) begin
                                    cmd_sel = CMD_READ_OCR;
                                end else begin
                                    dtype_next = CARD_SD1;
                                    cmd_sel    = CMD_SEND_CSD;
                                end
                            end else if (op_reg > 14'(opcond_to_reg)) begin
                                phase_next = PH_IDLE; done = 1'b1; stat = ST_OPCOND;
                            end else if (gap_reg == 8'd0) begin
                                do_cmd = 1'b1; cmd_sel = CMD_APP;
                            end else begin
                                phase_next = PH_GAP; ms_next = 13'd0;
                            end
                        end
                        GO_CSD:
                        begin
                            do_cmd = 1'b1; cmd_sel = CMD_SEND_CSD;
                        end
                        GO_CSDDONE:
                        begin
                            sectors_next = csd_sectors;
                            fast_next = 1'b1; phase_next = PH_IDLE; done = 1'b1;
                        end
                        GO_INITOK:
                        begin
                            fast_next = 1'b1; phase_next = PH_IDLE; done = 1'b1;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE; done = 1'b1; stat = hold_reg;
                        end
                    endcase
                end
                PH_TOKEN:
                begin
                    if (ms_reg > 13'(ready_to_reg)) begin
                        phase_next = PH_RELEASE; cs_n_next = 1'b1;
                        go_next   = is_csd ? GO_INITOK : GO_FINISH;
                        hold_next = is_csd ? ST_OK : ST_TOKEN_TO;
                    end else if (in_data.rx_byte == TOKEN_START) begin
                        phase_next = PH_RDATA; bc_next = 10'd0;
                    end else if (in_data.rx_byte != BYTE_IDLE) begin
                        phase_next = PH_RELEASE; cs_n_next = 1'b1;
                        go_next   = is_csd ? GO_INITOK : GO_FINISH;
                        hold_next = is_csd ? ST_OK : ST_BAD_TOKEN;
                    end
                end
                PH_RDATA:
                begin
                    if (is_csd) begin
                        if (bc_reg < CSD_BYTES) begin
                            rb_we  = 1'b1;
                            rb_idx = bc_reg[3:0];
                        end
                    end else if (bc_reg < BLOCK_BYTES) begin
                        rv = 1'b1;
                    end
                    bc_next = bc_inc;
                    if (bc_inc >= (is_csd ? CSD_BYTES + 10'd2 : BLOCK_BYTES + 10'd2)) begin
                        phase_next = PH_RELEASE; cs_n_next = 1'b1;
                        go_next = is_csd ? GO_CSDDONE : GO_FINISH; hold_next = ST_OK;
                    end
                end
                PH_WTOKEN:
                begin
                    phase_next = PH_WDATA; bc_next = 10'd0;
                end
                PH_WDATA:
                begin
                    bc_next = bc_inc;
                    if (bc_inc >= BLOCK_BYTES) begin
                        phase_next = PH_WTAIL; bc_next = 10'd0;
                    end
                end
                PH_WTAIL:
                begin
                    bc_next = bc_inc;
                    if (bc_inc >= 10'd3) begin
                        if ((in_data.rx_byte & DRESP_MASK) != DRESP_OK) begin
                            phase_next = PH_RELEASE; cs_n_next = 1'b1;
                            go_next = GO_FINISH; hold_next = ST_WR_REJECT;
                        end else begin
                            phase_next = PH_BUSY; ms_next = 13'd0;
                        end
                    end
                end
                PH_BUSY:
                begin
                    if (in_data.rx_byte == BYTE_IDLE) begin
                        phase_next = PH_RELEASE; cs_n_next = 1'b1;
                        go_next = GO_FINISH; hold_next = ST_OK;
                    end else if (ms_reg > 13'(wbusy_to_reg)) begin
                        phase_next = PH_RELEASE; cs_n_next = 1'b1;
                        go_next = GO_FINISH; hold_next = ST_BUSY_TO;
                    end
                end
                default:
                begin
                end
            endcase
        end else if (in_data.action == ACT_TICK) begin
            // Count a millisecond
            ms_next = ms_inc;
            op_next = (op_reg < OP_MAX) ? op_reg + 14'd1 : op_reg;
            if (phase_reg == PH_GAP && ms_inc >= 13'(gap_reg)) begin
                do_cmd = 1'b1; cmd_sel = CMD_APP;
            end
        end

        // Act on an R1 response
        if (r1_hit) begin
            case (cmd_cur)
                CMD_GO_IDLE:
                begin
                    phase_next = PH_RELEASE; cs_n_next = 1'b1;
                    go_next   = (r1 == 8'd1) ? GO_CMD8 : GO_FINISH;
                    hold_next = (r1 == 8'd1) ? ST_OK : ST_RESET;
                end
                CMD_IF_COND:
                begin
                    if (r1 == 8'd1) begin
                        phase_next = PH_RESP4; bc_next = 10'd0;
                    end else begin
                        v2_next = 1'b0; phase_next = PH_RELEASE; cs_n_next = 1'b1;
                        go_next = GO_ACMD_FIRST; hold_next = ST_OK;
                    end
                end
                CMD_APP:
                begin
                    do_cmd = 1'b1; cmd_sel = CMD_OP_COND;
                    arg_sel = v2_reg ? HCS_ARG : 32'd0;
                end
                CMD_OP_COND:
                begin
                    r1_zero_next = (r1 == 8'd0);
                    phase_next = PH_RELEASE; cs_n_next = 1'b1;
                    go_next = GO_OPCHECK; hold_next = ST_OK;
                end
                CMD_READ_OCR:
                begin
                    if (r1 == 8'd0) begin
                        phase_next = PH_RESP4; bc_next = 10'd0;
                    end else begin
                        dtype_next = CARD_SD2; phase_next = PH_RELEASE; cs_n_next = 1'b1;
                        go_next = GO_CSD; hold_next = ST_OK;
                    end
                end
                CMD_SEND_CSD:
                begin
                    if (r1 == 8'd0) begin
                        phase_next = PH_TOKEN; ms_next = 13'd0;
                    end else begin
                        phase_next = PH_RELEASE; cs_n_next = 1'b1;
                        go_next = GO_INITOK; hold_next = ST_OK;
                    end
                end
                CMD_RD_BLOCK:
                begin
                    if (r1 == 8'd0) begin
                        phase_next = PH_TOKEN; ms_next = 13'd0;
                    end else begin
                        phase_next = PH_RELEASE; cs_n_next = 1'b1;
                        go_next = GO_FINISH; hold_next = ST_REJECTED;
                    end
                end
                CMD_WR_BLOCK:
                begin
                    if (r1 == 8'd0) begin
                        phase_next = PH_WTOKEN;
                    end else begin
                        phase_next = PH_RELEASE; cs_n_next = 1'b1;
                        go_next = GO_FINISH; hold_next = ST_REJECTED;
                    end
                end
                default:
                begin
                    phase_next = PH_RELEASE; cs_n_next = 1'b1;
                    go_next = GO_FINISH; hold_next = ST_REJECTED;
                end
            endcase
        end

        // Launch a command: select the card and wait for ready
        if (do_cmd) begin
            frame_next = make_frame(cmd_sel, arg_sel);
            cs_n_next  = 1'b0;
            ms_next    = 13'd0;
            bc_next    = 10'd0;
            phase_next = (cmd_sel == CMD_WR_BLOCK && in_data.action == ACT_WRITE)
                         ? PH_PREWAIT : PH_WAITRDY;
        end
    end

    // Result for one step, from the state after it
    always_comb
    begin
        out_next.tx_valid        = (phase_next != PH_IDLE) && (phase_next != PH_GAP);
        out_next.need_write_byte = (phase_next == PH_WDATA);
        out_next.tx_byte         = BYTE_IDLE;
        if (phase_next == PH_FRAME && bc_next < 10'd6) begin
            case (bc_next[2:0])
                3'd0:    out_next.tx_byte = frame_next[47:40];
                3'd1:    out_next.tx_byte = frame_next[39:32];
                3'd2:    out_next.tx_byte = frame_next[31:24];
                3'd3:    out_next.tx_byte = frame_next[23:16];
                3'd4:    out_next.tx_byte = frame_next[15:8];
                default: out_next.tx_byte = frame_next[7:0];
            endcase
        end else if (phase_next == PH_WTOKEN) begin
            out_next.tx_byte = TOKEN_START;
        end
        out_next.chip_select_n = cs_n_next;
        out_next.fast_clock    = fast_next;
        out_next.read_valid    = rv;
        out_next.read_byte     = rv ? in_data.rx_byte : 8'd0;
        out_next.done_res      = done;
        out_next.status        = done ? stat : ST_OK;
        out_next.card_type     = dtype_next;
        out_next.sector_count  = sectors_next;
        out_next.busy_res      = (phase_next != PH_IDLE);
    end

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ready_to_reg  <= 12'd500;
            wbusy_to_reg  <= 12'd1000;
            opcond_to_reg <= 13'd2000;
            gap_reg       <= 8'd10;
            tries_reg     <= 4'd8;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_READY_TO:   ready_to_reg  <= cfg_data[11:0];
                CFG_WBUSY_TO:   wbusy_to_reg  <= cfg_data[11:0];
                CFG_OPCOND_TO:  opcond_to_reg <= cfg_data[12:0];
                CFG_RETRY_GAP:  gap_reg       <= cfg_data[7:0];
                CFG_RESP_TRIES: tries_reg     <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // Advance sequencer state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= PH_IDLE;
            go_reg      <= GO_FINISH;
            bc_reg      <= 10'd0;
            ms_reg      <= 13'd0;
            op_reg      <= 14'd0;
            tc_reg      <= 4'd0;
            frame_reg   <= 48'd0;
            v2_reg      <= 1'b0;
            dtype_reg   <= CARD_NONE;
            sectors_reg <= 32'd0;
            cs_n_reg    <= 1'b1;
            fast_reg    <= 1'b0;
            hold_reg    <= ST_OK;
            r1_zero_reg <= 1'b0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            go_reg      <= go_next;
            bc_reg      <= bc_next;
            ms_reg      <= ms_next;
            op_reg      <= op_next;
            tc_reg      <= tc_next;
            frame_reg   <= frame_next;
            v2_reg      <= v2_next;
            dtype_reg   <= dtype_next;
            sectors_reg <= sectors_next;
            cs_n_reg    <= cs_n_next;
            fast_reg    <= fast_next;
            hold_reg    <= hold_next;
            r1_zero_reg <= r1_zero_next;
        end
    end

    // Store response and CSD bytes
    always_ff @(posedge clk)
    begin
        if (accept && rb_we) begin
            regb_reg[rb_idx] <= in_data.rx_byte;
        end
    end

    // Drop or refill the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.busy_res |-> !out_reg.tx_valid)
        else $error("exchange requested while idle");
    a_write_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.need_write_byte |-> out_reg.tx_byte == BYTE_IDLE)
        else $error("command byte during write data");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.done_res |-> !out_reg.busy_res)
        else $error("request done but still busy");
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.read_valid |-> out_reg.busy_res && !out_reg.chip_select_n)
        else $error("read data outside a selected transfer");
    a_idle_deselect: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> cs_n_reg)
        else $error("card left selected while idle");
`endif

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the SD card SPI-mode host sequencer.
`timescale 1ns / 1ps
module tb_top;
    import sdspi_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_t                   in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_t                  out_data;
    logic                  cfg_write;
    logic [2:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sd_card_spi_host_sequencer_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock, 8 ns period
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Sequencer state mirrored by the predictor
    phase_t      ph;
    go_t         nxt;
    logic [47:0] frame;
    logic [9:0]  bcnt;
    logic [12:0] mst;
    logic [13:0] opt;
    logic [3:0]  tries;
    logic        v2;
    logic [1:0]  ctype;
    logic [31:0] sectors;
    logic [7:0]  regs [16];
    logic        csn;
    logic        fst;
    logic [3:0]  hold_st;
    logic [7:0]  last_r1;
    logic        o_done;
    logic [3:0]  o_st;
    logic        o_rv;
    logic [7:0]  o_rb;

    // Mirrored configuration
    logic [11:0] cfg_rdy;
    logic [11:0] cfg_wbusy;
    logic [12:0] cfg_op;
    logic [7:0]  cfg_gap;
    logic [3:0]  cfg_tries;

    out_t        want_q [$];
    int          mismatches;
    int          items_sent;
    int          results_seen;
    int          requests_done;
    int          tx_max_gap;
    int          rx_max_gap;
    bit          long_hold;
    bit          long_done;

    function automatic void begin_command(input logic [5:0] c, input logic [31:0] arg);
        logic [7:0] crc;
        crc   = (c == CMD_GO_IDLE) ? 8'h95 : (c == CMD_IF_COND) ? 8'h87 : 8'h01;
        frame = {2'b01, c, arg, crc};
        csn   = 1'b0;
        ph    = PH_WAITRDY;
        mst   = '0;
        bcnt  = '0;
    endfunction

    function automatic void release_card(input go_t g, input logic [3:0] st);
        ph      = PH_RELEASE;
        csn     = 1'b1;
        nxt     = g;
        hold_st = st;
    endfunction

    function automatic void end_request(input logic [3:0] st);
        ph     = PH_IDLE;
        o_done = 1'b1;
        o_st   = st;
    endfunction

    // Work out the sector count from the captured CSD
    function automatic void capacity_from_csd();
        logic [21:0] csz2;
        logic [11:0] csz1;
        logic [2:0]  mult;
        logic [3:0]  bl;
        logic [63:0] cap;
        if (regs[0][7:6] == 2'd1)
        begin
            csz2    = {regs[7][5:0], regs[8], regs[9]};
            sectors = (32'(csz2) + 32'd1) * 32'd1024;
        end
        else if (regs[0][7:6] == 2'd0)
        begin
            csz1    = {regs[6][1:0], regs[7], regs[8][7:6]};
            mult    = {regs[9][1:0], regs[10][7]};
            bl      = regs[5][3:0];
            cap     = (64'(csz1) + 64'd1) << (32'(mult) + 32'd2 + 32'(bl));
            sectors = cap[40:9];
        end
    endfunction

    function automatic void after_release(input go_t g);
        case (g)
            GO_CMD8:       begin_command(CMD_IF_COND, IF_COND_ARG);
            GO_ACMD_FIRST:
            begin
                opt = '0;
                begin_command(CMD_APP, '0);
            end
            GO_OPCHECK:
            begin
                if (last_r1 == 8'h00)
                begin
                    if (v2)
                        begin_command(CMD_READ_OCR, '0);
                    else
                    begin
                        ctype = CARD_SD1;
                        begin_command(CMD_SEND_CSD, '0);
                    end
                end
                else if (opt > 14'(cfg_op))
                    end_request(ST_OPCOND);
                else if (cfg_gap == 8'd0)
                    begin_command(CMD_APP, '0);
                else
                begin
                    ph  = PH_GAP;
                    mst = '0;
                end
            end
            GO_CSD:        begin_command(CMD_SEND_CSD, '0);
            GO_CSDDONE:
            begin
                capacity_from_csd();
                fst = 1'b1;
                end_request(ST_OK);
            end
            GO_INITOK:
            begin
                fst = 1'b1;
                end_request(ST_OK);
            end
            default:       end_request(hold_st);
        endcase
    endfunction

    function automatic void take_r1(input logic [7:0] r);
        case (frame[45:40])
            CMD_GO_IDLE:
                if (r == 8'h01) release_card(GO_CMD8, ST_OK);
                else release_card(GO_FINISH, ST_RESET);
            CMD_IF_COND:
                if (r == 8'h01)
                begin
                    ph   = PH_RESP4;
                    bcnt = '0;
                end
                else
                begin
                    v2 = 1'b0;
                    release_card(GO_ACMD_FIRST, ST_OK);
                end
            CMD_APP:      begin_command(CMD_OP_COND, v2 ? HCS_ARG : 32'd0);
            CMD_OP_COND:
            begin
                last_r1 = r;
                release_card(GO_OPCHECK, ST_OK);
            end
            CMD_READ_OCR:
                if (r == 8'h00)
                begin
                    ph   = PH_RESP4;
                    bcnt = '0;
                end
                else
                begin
                    ctype = CARD_SD2;
                    release_card(GO_CSD, ST_OK);
                end
            CMD_SEND_CSD:
                if (r == 8'h00)
                begin
                    ph  = PH_TOKEN;
                    mst = '0;
                end
                else release_card(GO_INITOK, ST_OK);
            CMD_RD_BLOCK:
                if (r == 8'h00)
                begin
                    ph  = PH_TOKEN;
                    mst = '0;
                end
                else release_card(GO_FINISH, ST_REJECTED);
            CMD_WR_BLOCK:
                if (r == 8'h00) ph = PH_WTOKEN;
                else release_card(GO_FINISH, ST_REJECTED);
            default:      release_card(GO_FINISH, ST_REJECTED);
        endcase
    endfunction

    function automatic void take_byte(input logic [7:0] rx);
        logic csd;
        csd = (frame[45:40] == CMD_SEND_CSD);
        case (ph)
            PH_IDLECLK:
            begin
                bcnt++;
                if (bcnt >= 10'(i_dut.IDLE_CLOCK_BYTES + 1)) begin_command(CMD_GO_IDLE, '0);
            end
            PH_PREWAIT:
                if (rx == BYTE_IDLE)
                begin
                    ph  = PH_WAITRDY;
                    mst = '0;
                end
                else if (mst > 13'(cfg_rdy)) release_card(GO_FINISH, ST_BUSY_TO);
            PH_WAITRDY:
                if (rx == BYTE_IDLE || mst > 13'(cfg_rdy))
                begin
                    ph   = PH_FRAME;
                    bcnt = '0;
                end
            PH_FRAME:
            begin
                bcnt++;
                if (bcnt >= 10'd6)
                begin
                    ph    = PH_R1;
                    tries = '0;
                end
            end
            PH_R1:
                if (!rx[7]) take_r1(rx);
                else
                begin
                    tries++;
                    if (tries == 4'd0 || tries >= cfg_tries) take_r1(8'hFF);
                end
            PH_RESP4:
            begin
                regs[bcnt[1:0]] = rx;
                bcnt++;
                if (bcnt >= 10'd4)
                begin
                    if (frame[45:40] == CMD_IF_COND)
                    begin
                        if (regs[2][3:0] == 4'h1 && regs[3] == 8'hAA)
                        begin
                            v2 = 1'b1;
                            release_card(GO_ACMD_FIRST, ST_OK);
                        end
                        else release_card(GO_FINISH, ST_VOLTAGE);
                    end
                    else
                    begin
                        ctype = regs[0][6] ? CARD_HC : CARD_SD2;
                        release_card(GO_CSD, ST_OK);
                    end
                end
            end
            PH_RELEASE: after_release(nxt);
            PH_TOKEN:
                if (mst > 13'(cfg_rdy))
                begin
                    if (csd) release_card(GO_INITOK, ST_OK);
                    else release_card(GO_FINISH, ST_TOKEN_TO);
                end
                else if (rx == BYTE_IDLE)
                    ;
                else if (rx == TOKEN_START)
                begin
                    ph   = PH_RDATA;
                    bcnt = '0;
                end
                else if (csd) release_card(GO_INITOK, ST_OK);
                else release_card(GO_FINISH, ST_BAD_TOKEN);
            PH_RDATA:
            begin
                if (csd)
                begin
                    if (bcnt < CSD_BYTES) regs[bcnt[3:0]] = rx;
                end
                else if (bcnt < BLOCK_BYTES)
                begin
                    o_rv = 1'b1;
                    o_rb = rx;
                end
                bcnt++;
                if (bcnt >= (csd ? CSD_BYTES + 10'd2 : BLOCK_BYTES + 10'd2))
                    release_card(csd ? GO_CSDDONE : GO_FINISH, ST_OK);
            end
            PH_WTOKEN:
            begin
                ph   = PH_WDATA;
                bcnt = '0;
            end
            PH_WDATA:
            begin
                bcnt++;
                if (bcnt >= BLOCK_BYTES)
                begin
                    ph   = PH_WTAIL;
                    bcnt = '0;
                end
            end
            PH_WTAIL:
            begin
                bcnt++;
                if (bcnt >= 10'd3)
                begin
                    if ((rx & DRESP_MASK) != DRESP_OK) release_card(GO_FINISH, ST_WR_REJECT);
                    else
                    begin
                        ph  = PH_BUSY;
                        mst = '0;
                    end
                end
            end
            PH_BUSY:
                if (rx == BYTE_IDLE) release_card(GO_FINISH, ST_OK);
                else if (mst > 13'(cfg_wbusy)) release_card(GO_FINISH, ST_BUSY_TO);
            default: ;
        endcase
    endfunction

    // Advance the mirrored sequencer by one beat and give the result it shows
    function automatic out_t sequencer_step(input in_t it);
        out_t        r;
        logic [31:0] a;
        o_done = 1'b0;
        o_st   = ST_OK;
        o_rv   = 1'b0;
        o_rb   = 8'h00;
        if (it.action <= ACT_WRITE && ph == PH_IDLE)
        begin
            if (it.action == ACT_INIT)
            begin
                ctype   = CARD_NONE;
                sectors = '0;
                v2      = 1'b0;
                fst     = 1'b0;
                csn     = 1'b1;
                ph      = PH_IDLECLK;
                bcnt    = '0;
            end
            else if (ctype == CARD_NONE)
                end_request(ST_NO_CARD);
            else
            begin
                a = (ctype == CARD_HC) ? it.block_address : {it.block_address[22:0], 9'd0};
                begin_command(it.action == ACT_READ ? CMD_RD_BLOCK : CMD_WR_BLOCK, a);
                if (it.action == ACT_WRITE) ph = PH_PREWAIT;
            end
        end
        else if (it.action == ACT_BYTE)
            take_byte(it.rx_byte);
        else if (it.action == ACT_TICK)
        begin
            if (mst < MS_MAX) mst++;
            if (opt < OP_MAX) opt++;
            if (ph == PH_GAP && mst >= 13'(cfg_gap)) begin_command(CMD_APP, '0);
        end
        r.tx_valid        = (ph != PH_IDLE && ph != PH_GAP);
        r.need_write_byte = (ph == PH_WDATA);
        r.tx_byte         = BYTE_IDLE;
        if (ph == PH_FRAME && bcnt < 10'd6)
            r.tx_byte = frame[8 * (5 - bcnt) +: 8];
        else if (ph == PH_WTOKEN)
            r.tx_byte = TOKEN_START;
        r.chip_select_n   = csn;
        r.fast_clock      = fst;
        r.read_valid      = o_rv;
        r.read_byte       = o_rb;
        r.done_res        = o_done;
        r.status          = o_st;
        r.card_type       = ctype;
        r.sector_count    = sectors;
        r.busy_res        = (ph != PH_IDLE);
        return r;
    endfunction

    function automatic logic [7:0] pick(input int pct, input logic [7:0] good);
        return ($urandom_range(0, 99) < pct) ? good : 8'($urandom);
    endfunction

    // Card reply that moves the current step on most of the time
    function automatic logic [7:0] card_reply();
        logic [7:0] good;
        case (ph)
            PH_WAITRDY, PH_PREWAIT: return pick(80, BYTE_IDLE);
            PH_R1:
            begin
                case (frame[45:40])
                    CMD_GO_IDLE, CMD_APP: good = 8'h01;
                    CMD_IF_COND: good = ($urandom_range(0, 9) < 7) ? 8'h01 : 8'h05;
                    CMD_OP_COND: good = $urandom_range(0, 1) ? 8'h00 : 8'h01;
                    default:     good = 8'h00;
                endcase
                return pick(85, good);
            end
            PH_RESP4:
                if (frame[45:40] == CMD_IF_COND && bcnt == 10'd2)
                    return pick(90, {4'($urandom), 4'h1});
                else if (frame[45:40] == CMD_IF_COND && bcnt == 10'd3)
                    return pick(90, 8'hAA);
                else
                    return 8'($urandom);
            PH_TOKEN:  return ($urandom_range(0, 99) < 15) ? BYTE_IDLE : pick(88, TOKEN_START);
            PH_RDATA:
                if (frame[45:40] == CMD_SEND_CSD && bcnt == 10'd0)
                begin
                    good = pick(90, {7'd0, 1'($urandom)});
                    return {good[1:0], 6'($urandom)};
                end
                else
                    return 8'($urandom);
            PH_WTAIL:
                if (bcnt == 10'd2) return pick(85, {3'($urandom), 5'h05});
                else return 8'($urandom);
            PH_BUSY:   return pick(35, BYTE_IDLE);
            default:   return 8'($urandom);
        endcase
    endfunction

    // Next random beat: mostly well-formed card traffic, some noise
    function automatic in_t random_beat();
        in_t it;
        int  r;
        r                = $urandom_range(0, 99);
        it.rx_byte       = 8'($urandom);
        it.write_byte    = 8'($urandom);
        case ($urandom_range(0, 3))
            0:       it.block_address = 32'd0;
            1:       it.block_address = 32'hFFFF_FFFF;
            default: it.block_address = $urandom;
        endcase
        if (r < 3)
            it.action = 3'($urandom_range(5, 7));
        else if (r < 13 || ph == PH_GAP)
            it.action = ACT_TICK;
        else if (ph == PH_IDLE)
        begin
            if ($urandom_range(0, 99) < ((ctype == CARD_NONE) ? 60 : 20))
                it.action = ACT_INIT;
            else
                it.action = $urandom_range(0, 1) ? ACT_READ : ACT_WRITE;
        end
        else if (r < 16)
            it.action = 3'($urandom_range(0, 2));
        else
        begin
            it.action  = ACT_BYTE;
            it.rx_byte = card_reply();
        end
        return it;
    endfunction

    // Offer one beat, hold it until taken, then record what it should give
    task automatic send_beat(input in_t it, input bit fixed, input out_t want);
        int   gap;
        out_t got;
        bit   ignored;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        ignored = (it.action > ACT_TICK) || (it.action <= ACT_WRITE && ph != PH_IDLE)
                  || (it.action == ACT_BYTE && (ph == PH_IDLE || ph == PH_GAP));
        got = sequencer_step(it);
        if (!ignored) items_sent++;
        if (got.done_res) requests_done++;
        want_q.push_back(fixed ? want : got);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait for a quiet block, then load all five registers
    task automatic load_config(input logic [11:0] rdy, input logic [11:0] wb,
                               input logic [12:0] op, input logic [7:0] gp,
                               input logic [3:0] tr);
        while (want_q.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_READY_TO;
        cfg_data  <= 13'(rdy);
        @(posedge clk);
        cfg_index <= CFG_WBUSY_TO;
        cfg_data  <= 13'(wb);
        @(posedge clk);
        cfg_index <= CFG_OPCOND_TO;
        cfg_data  <= op;
        @(posedge clk);
        cfg_index <= CFG_RETRY_GAP;
        cfg_data  <= 13'(gp);
        @(posedge clk);
        cfg_index <= CFG_RESP_TRIES;
        cfg_data  <= 13'(tr);
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_rdy   = rdy;
        cfg_wbusy = wb;
        cfg_op    = op;
        cfg_gap   = gp;
        cfg_tries = tr;
    endtask

    task automatic note_field(input string name, input logic [31:0] e, input logic [31:0] a,
                              inout bit bad);
        if (e !== a)
        begin
            if (mismatches < 10)
                $display("%0t: %s expected %0h got %0h", $realtime, name, e, a);
            bad = 1'b1;
        end
    endtask

    // Compare a taken result with the oldest expectation
    task automatic check_result(input out_t a);
        out_t e;
        bit   bad;
        bad = 1'b0;
        results_seen++;
        if (want_q.size() == 0)
        begin
            if (mismatches < 10) $display("%0t: result with nothing expected", $realtime);
            mismatches++;
        end
        else
        begin
            e = want_q.pop_front();
            note_field("tx_valid", e.tx_valid, a.tx_valid, bad);
            note_field("tx_byte", e.tx_byte, a.tx_byte, bad);
            note_field("chip_select_n", e.chip_select_n, a.chip_select_n, bad);
            note_field("fast_clock", e.fast_clock, a.fast_clock, bad);
            note_field("read_valid", e.read_valid, a.read_valid, bad);
            note_field("read_byte", e.read_byte, a.read_byte, bad);
            note_field("need_write_byte", e.need_write_byte, a.need_write_byte, bad);
            note_field("done_res", e.done_res, a.done_res, bad);
            note_field("status", e.status, a.status, bad);
            note_field("card_type", e.card_type, a.card_type, bad);
            note_field("sector_count", e.sector_count, a.sector_count, bad);
            note_field("busy_res", e.busy_res, a.busy_res, bad);
            if (bad) mismatches++;
        end
    endtask

    // Result side: random stalls, and one long hold-off on request
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold && !long_done)
            begin
                stall     = 300;
                long_done = 1'b1;
            end
            else
                stall = $urandom_range(0, rx_max_gap);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            check_result(out_data);
        end
    end

    // Directed rows; fixed expectations only where they are obvious
    typedef struct {
        in_t  it;
        bit   fixed;
        out_t want;
    } row_t;

    row_t rows [$];

    function automatic out_t idle_out(input logic done, input logic [3:0] st);
        out_t o;
        o               = '0;
        o.tx_byte       = BYTE_IDLE;
        o.chip_select_n = 1'b1;
        o.done_res      = done;
        o.status        = st;
        o.card_type     = CARD_NONE;
        return o;
    endfunction

    function automatic void add_row(input logic [2:0] act, input logic [31:0] addr,
                                    input logic [7:0] rx, input logic [7:0] wb,
                                    input bit fixed, input out_t want);
        row_t r;
        r.it.action        = act;
        r.it.block_address = addr;
        r.it.rx_byte       = rx;
        r.it.write_byte    = wb;
        r.fixed            = fixed;
        r.want             = want;
        rows.push_back(r);
    endfunction

    // Stimulus
    initial
    begin
        out_t first_busy;
        int   quota;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        ph = PH_IDLE; nxt = GO_FINISH; frame = '0; bcnt = '0; mst = '0; opt = '0;
        tries = '0; v2 = 1'b0; ctype = CARD_NONE; sectors = '0; csn = 1'b1; fst = 1'b0;
        hold_st = ST_OK; last_r1 = '0;
        foreach (regs[i]) regs[i] = '0;
        cfg_rdy = 12'd500; cfg_wbusy = 12'd1000; cfg_op = 13'd2000;
        cfg_gap = 8'd10; cfg_tries = 4'd8;
        items_sent = 0; requests_done = 0;
        tx_max_gap = 14; rx_max_gap = 14; long_hold = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_config(12'd500, 12'd1000, 13'd2000, 8'd10, 4'd8);

        // Requests with no card, ignored codes, then the start of an init
        first_busy               = idle_out(1'b0, ST_OK);
        first_busy.tx_valid      = 1'b1;
        first_busy.busy_res      = 1'b1;
        add_row(ACT_READ, 32'd0, 8'h00, 8'h00, 1, idle_out(1'b1, ST_NO_CARD));
        add_row(ACT_WRITE, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1, idle_out(1'b1, ST_NO_CARD));
        add_row(3'd5, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1, idle_out(1'b0, ST_OK));
        add_row(3'd6, 32'd0, 8'h00, 8'h00, 1, idle_out(1'b0, ST_OK));
        add_row(3'd7, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1, idle_out(1'b0, ST_OK));
        add_row(ACT_BYTE, 32'd0, 8'h00, 8'hFF, 1, idle_out(1'b0, ST_OK));
        add_row(ACT_TICK, 32'd0, 8'hFF, 8'h00, 1, idle_out(1'b0, ST_OK));
        add_row(ACT_INIT, 32'd0, 8'h00, 8'h00, 1, first_busy);
        add_row(ACT_INIT, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 0, first_busy);
        add_row(ACT_READ, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 0, first_busy);
        add_row(ACT_WRITE, 32'd0, 8'h00, 8'h00, 0, first_busy);
        for (int k = 0; k < 12; k++)
            add_row(ACT_BYTE, $urandom, 8'($urandom), 8'($urandom), 0, first_busy);
        foreach (rows[i]) send_beat(rows[i].it, rows[i].fixed, rows[i].want);

        // Random phases, with new register settings loaded between phases
        for (int p = 0; p < 6; p++)
        begin
            quota = items_sent + 70;
            tx_max_gap = (p == 1) ? 0 : 14;
            rx_max_gap = (p == 1) ? 0 : 14;
            if (p == 2) long_hold = 1'b1;
            while (items_sent < quota || ph != PH_IDLE)
            begin
                send_beat(random_beat(), 0, first_busy);
                // Let every result drain once mid-phase
                if (p == 3 && items_sent == quota - 35)
                begin
                    drop_valid();
                    while (want_q.size() != 0) @(posedge clk);
                end
            end
            drop_valid();
            case (p)
                0: load_config(12'd1, 12'd1, 13'd1, 8'd0, 4'd1);
                1: load_config(12'd4095, 12'd4095, 13'd8191, 8'd255, 4'd15);
                2: load_config(12'($urandom), 12'($urandom), 13'($urandom), 8'($urandom),
                               4'($urandom));
                3: load_config(12'd3, 12'd2, 13'd5, 8'd1, 4'd0);
                4: load_config(12'd500, 12'd1000, 13'd2000, 8'd10, 4'd8);
                default: ;
            endcase
        end

        // Drain and settle
        for (int w = 0; w < 20000 && want_q.size() != 0; w++) @(posedge clk);
        if (want_q.size() != 0)
        begin
            $display("%0d results never arrived", want_q.size());
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            repeat (4) @(posedge clk);
            $display("Covered %0d beats and %0d results, %0d requests ended, over six settings.",
                     items_sent, results_seen, requests_done);
            if (mismatches == 0)
                $display("No mismatches found");
            else
                $display("Mismatches found");
            $finish;
        end
    end

    // Guard against a hung handshake
    initial
    begin
        #20_000_000;
        $display("Run timed out");
        $display("Mismatches found");
        $finish;
    end

endmodule
